FILE: src/trc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trc_pkg
// types, codes and helpers shared by the triangle rasterizer blocks
// ----------------------------------------------------------------------------
package trc_pkg;

	localparam int MAX_WIDTH_DEF  = 64;
	localparam int MAX_HEIGHT_DEF = 64;

	localparam logic [23:0] WHITE     = 24'hFFFFFF;
	localparam logic [12:0] COUNT_MAX = 13'd8191;

	localparam int CW = 13; // clamped box coordinates, signed
	localparam int MW = 18; // multiplier operands, signed
	localparam int EW = 40; // edge function accumulators, signed

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_DRAW  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [15:0] vertex_a_x;
		logic signed [15:0] vertex_a_y;
		logic signed [15:0] vertex_b_x;
		logic signed [15:0] vertex_b_y;
		logic signed [15:0] vertex_c_x;
		logic signed [15:0] vertex_c_y;
		logic [15:0]        color_level;
		logic [5:0]         read_column;
		logic [5:0]         read_row;
	} item_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        degenerate;
		logic [12:0] pixels_written;
	} result_t;

	typedef struct packed {
		logic       load;
		logic       sweep;
		logic       mul_go;
		logic [2:0] mul_idx;
		logic       walk_init;
		logic       walk;
		logic       rd_issue;
		logic       res_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic area_zero;
		logic box_empty;
		logic walk_last;
	} dp_status_t;

	// four-segment jet ramp, 0.16 level to packed rgb
	function automatic logic [23:0] jet(input logic [15:0] lv);
		logic [21:0] prod;
		logic [21:0] rsum;
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [23:0] rgb;
		prod = {lv[13:0], 8'b0} - {8'b0, lv[13:0]};
		rsum = prod + 22'd16383;
		lo   = prod[21:14];
		hi   = rsum[21:14];
		case (lv[15:14])
			2'd0:    rgb = {8'd0, lo, 8'd255};
			2'd1:    rgb = {8'd0, 8'd255, 8'd255 - hi};
			2'd2:    rgb = {lo, 8'd255, 8'd0};
			default: rgb = {8'd255, 8'd255 - hi, 8'd0};
		endcase
		return rgb;
	endfunction

	function automatic logic signed [MW-1:0] diff(input logic signed [16:0] a,
		input logic signed [16:0] b);
		return MW'(a) - MW'(b);
	endfunction

endpackage
`default_nettype wire

FILE: src/trc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trc_ram
// generic ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module trc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

FILE: src/trc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trc_ctrl
// command sequencer: store sweep, setup products, pixel walk, read, result
// ----------------------------------------------------------------------------
module trc_ctrl import trc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_ready,
	input  wire logic [1:0] item_command,
	output logic            result_valid,
	input  wire logic       result_ready,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);
	typedef enum logic [7:0] {
		ST_INIT  = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_CLEAR = 8'b0000_0100,
		ST_SETUP = 8'b0000_1000,
		ST_CHECK = 8'b0001_0000,
		ST_WALK  = 8'b0010_0000,
		ST_READ  = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t     state_q, state_d;
	logic [3:0] step_q;
	logic       res_valid_q;
	logic       accept;

	assign item_ready   = (state_q == ST_IDLE);
	assign accept       = item_valid && item_ready;
	assign result_valid = res_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				cmd.sweep = 1'b1;
				if (status.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					case (item_command)
						CMD_CLEAR: state_d = ST_CLEAR;
						CMD_DRAW:  state_d = ST_SETUP;
						CMD_READ:  state_d = ST_READ;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (status.sweep_last) state_d = ST_DONE;
			end
			ST_SETUP: begin
				cmd.mul_go  = !step_q[3];
				cmd.mul_idx = step_q[2:0];
				// one extra step drains the product register
				if (step_q[3]) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (status.area_zero || status.box_empty) begin
					state_d = ST_DONE;
				end else begin
					cmd.walk_init = 1'b1;
					state_d       = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (status.walk_last) state_d = ST_DONE;
			end
			ST_READ: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				if (!res_valid_q || result_ready) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				step_q <= '0;
			end else if (state_q == ST_SETUP) begin
				step_q <= step_q + 4'd1;
			end
			if (cmd.res_load) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

FILE: src/trc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trc_datapath
// box clamp, shared setup multiplier, incremental edge walk, frame store
// ----------------------------------------------------------------------------
module trc_datapath import trc_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       write_enable,
	input  wire logic [1:0] register_index,
	input  wire logic [6:0] write_data,
	input  wire item_t      item,
	input  wire ctrl_cmd_t  cmd,
	output dp_status_t      status,
	output result_t         result
);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [6:0]  width_q, height_q;
	logic [10:0] w_act, h_act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 7'd64;
			height_q <= 7'd64;
		end else if (write_enable) begin
			case (register_index)
				REG_WIDTH:  width_q  <= write_data;
				REG_HEIGHT: height_q <= write_data;
				default: ;
			endcase
		end
	end

	// out-of-range sizes count as one or as the maximum
	always_comb begin
		w_act = {4'b0, width_q};
		h_act = {4'b0, height_q};
		if (width_q == 7'd0) w_act = 11'd1;
		else if ({4'b0, width_q} > 11'(MAX_WIDTH)) w_act = 11'(MAX_WIDTH);
		if (height_q == 7'd0) h_act = 11'd1;
		else if ({4'b0, height_q} > 11'(MAX_HEIGHT)) h_act = 11'(MAX_HEIGHT);
	end

	// bounding box of the incoming item
	logic signed [15:0] minx, maxx, miny, maxy;
	logic signed [16:0] cex, cey;
	logic signed [CW-1:0] flx, fly, clx, cly, wm1, hm1;
	logic signed [CW-1:0] bx0_d, bx1_d, by0_d, by1_d;

	always_comb begin
		minx = item.vertex_a_x;
		maxx = item.vertex_a_x;
		miny = item.vertex_a_y;
		maxy = item.vertex_a_y;
		if (item.vertex_b_x < minx) minx = item.vertex_b_x;
		if (item.vertex_c_x < minx) minx = item.vertex_c_x;
		if (item.vertex_b_x > maxx) maxx = item.vertex_b_x;
		if (item.vertex_c_x > maxx) maxx = item.vertex_c_x;
		if (item.vertex_b_y < miny) miny = item.vertex_b_y;
		if (item.vertex_c_y < miny) miny = item.vertex_c_y;
		if (item.vertex_b_y > maxy) maxy = item.vertex_b_y;
		if (item.vertex_c_y > maxy) maxy = item.vertex_c_y;
		flx = CW'(minx >>> 4);
		fly = CW'(miny >>> 4);
		cex = (17'(maxx) + 17'sd15) >>> 4;
		cey = (17'(maxy) + 17'sd15) >>> 4;
		clx = CW'(cex);
		cly = CW'(cey);
		wm1 = $signed({2'b0, w_act - 11'd1});
		hm1 = $signed({2'b0, h_act - 11'd1});
		bx0_d = (flx < 0) ? '0 : flx;
		by0_d = (fly < 0) ? '0 : fly;
		bx1_d = (clx > wm1) ? wm1 : clx;
		by1_d = (cly > hm1) ? hm1 : cly;
	end

	item_t               item_q;
	logic [23:0]         colour_q;
	logic signed [CW-1:0] bx0_q, bx1_q, by0_q, by1_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q   <= item;
			colour_q <= jet(item.color_level);
			bx0_q    <= bx0_d;
			bx1_q    <= bx1_d;
			by0_q    <= by0_d;
			by1_q    <= by1_d;
		end
	end

	// edge deltas of the stored triangle
	logic signed [MW-1:0] dx01, dy01, dx12, dy12, dx20, dy20;
	logic signed [MW-1:0] dx02, dy02;
	logic signed [MW-1:0] pxa, pxb, pxc, pya, pyb, pyc;
	logic signed [16:0]   px0, py0;

	assign px0  = $signed({bx0_q, 4'b1000});
	assign py0  = $signed({by0_q, 4'b1000});
	assign dx01 = diff(item_q.vertex_b_x, item_q.vertex_a_x);
	assign dy01 = diff(item_q.vertex_b_y, item_q.vertex_a_y);
	assign dx12 = diff(item_q.vertex_c_x, item_q.vertex_b_x);
	assign dy12 = diff(item_q.vertex_c_y, item_q.vertex_b_y);
	assign dx20 = diff(item_q.vertex_a_x, item_q.vertex_c_x);
	assign dy20 = diff(item_q.vertex_a_y, item_q.vertex_c_y);
	assign dx02 = diff(item_q.vertex_c_x, item_q.vertex_a_x);
	assign dy02 = diff(item_q.vertex_c_y, item_q.vertex_a_y);
	assign pxa  = diff(px0, item_q.vertex_a_x);
	assign pxb  = diff(px0, item_q.vertex_b_x);
	assign pxc  = diff(px0, item_q.vertex_c_x);
	assign pya  = diff(py0, item_q.vertex_a_y);
	assign pyb  = diff(py0, item_q.vertex_b_y);
	assign pyc  = diff(py0, item_q.vertex_c_y);

	// shared multiplier for the doubled area and the three origin edge values
	logic signed [MW-1:0]   op_a, op_b;
	logic signed [2*MW-1:0] prod_s1;
	logic [2:0]             tag_s1;
	logic                   mv_s1;

	always_comb begin
		case (cmd.mul_idx)
			3'd0:    begin op_a = dx01; op_b = dy02; end
			3'd1:    begin op_a = dy01; op_b = dx02; end
			3'd2:    begin op_a = dx12; op_b = pyb;  end
			3'd3:    begin op_a = dy12; op_b = pxb;  end
			3'd4:    begin op_a = dx20; op_b = pyc;  end
			3'd5:    begin op_a = dy20; op_b = pxc;  end
			3'd6:    begin op_a = dx01; op_b = pya;  end
			default: begin op_a = dy01; op_b = pxa;  end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		tag_s1  <= cmd.mul_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_s1 <= 1'b0;
		end else begin
			mv_s1 <= cmd.mul_go;
		end
	end

	// per-edge steps along x and y, sixteen sub-pixel units each
	logic signed [EW-1:0] stx [3];
	logic signed [EW-1:0] sty [3];

	assign stx[0] = -(EW'(dy12) <<< 4);
	assign sty[0] =   EW'(dx12) <<< 4;
	assign stx[1] = -(EW'(dy20) <<< 4);
	assign sty[1] =   EW'(dx20) <<< 4;
	assign stx[2] = -(EW'(dy01) <<< 4);
	assign sty[2] =   EW'(dx01) <<< 4;

	logic signed [EW-1:0] area_q;
	logic signed [EW-1:0] e_row_q [3];
	logic signed [EW-1:0] e_cur_q [3];
	logic signed [EW-1:0] pe;
	logic [1:0]           acc_edge;
	logic                 acc_neg;

	assign pe       = EW'(prod_s1);
	assign acc_edge = 2'(tag_s1[2:1] - 2'd1);
	assign acc_neg  = tag_s1[0];

	logic signed [CW-1:0] x_q, y_q;
	logic [AW-1:0]        row_base_q;
	logic [12:0]          count_q;
	logic                 covered;
	logic                 row_end;

	assign row_end = (x_q == bx1_q);
	assign covered = (!area_q[EW-1])
		? (!e_cur_q[0][EW-1] && !e_cur_q[1][EW-1] && !e_cur_q[2][EW-1])
		: ((e_cur_q[0][EW-1] || e_cur_q[0] == 0) && (e_cur_q[1][EW-1] || e_cur_q[1] == 0)
			&& (e_cur_q[2][EW-1] || e_cur_q[2] == 0));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			area_q  <= '0;
			count_q <= '0;
			for (int i = 0; i < 3; i++) begin
				e_row_q[i] <= '0;
				e_cur_q[i] <= '0;
			end
		end else if (mv_s1) begin
			if (tag_s1[2:1] == 2'd0) begin
				area_q <= acc_neg ? area_q - pe : area_q + pe;
			end else begin
				e_row_q[acc_edge] <= acc_neg ? e_row_q[acc_edge] - pe : e_row_q[acc_edge] + pe;
				e_cur_q[acc_edge] <= acc_neg ? e_cur_q[acc_edge] - pe : e_cur_q[acc_edge] + pe;
			end
		end else if (cmd.walk_init) begin
			x_q        <= bx0_q;
			y_q        <= by0_q;
			row_base_q <= AW'(int'(by0_q) * MAX_WIDTH);
		end else if (cmd.walk) begin
			if (covered && count_q != COUNT_MAX) count_q <= count_q + 13'd1;
			if (row_end) begin
				x_q        <= bx0_q;
				y_q        <= y_q + CW'(1);
				row_base_q <= row_base_q + AW'(MAX_WIDTH);
				for (int i = 0; i < 3; i++) begin
					e_row_q[i] <= e_row_q[i] + sty[i];
					e_cur_q[i] <= e_row_q[i] + sty[i];
				end
			end else begin
				x_q <= x_q + CW'(1);
				for (int i = 0; i < 3; i++) begin
					e_cur_q[i] <= e_cur_q[i] + stx[i];
				end
			end
		end
	end

	// store sweep for reset and clear
	logic [AW-1:0] sweep_q;
	logic          sweep_last;

	assign sweep_last = (sweep_q == AW'(DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep) begin
			sweep_q <= sweep_last ? '0 : sweep_q + AW'(1);
		end
	end

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [23:0]   ram_wdata, ram_rdata;
	logic          rd_in_range;

	assign ram_we    = cmd.sweep || (cmd.walk && covered);
	assign ram_waddr = cmd.sweep ? sweep_q : row_base_q + AW'(x_q);
	assign ram_wdata = cmd.sweep ? WHITE : colour_q;
	assign ram_raddr = AW'(int'(item_q.read_row) * MAX_WIDTH + int'(item_q.read_column));
	assign rd_in_range = (int'(item_q.read_column) < MAX_WIDTH)
		&& (int'(item_q.read_row) < MAX_HEIGHT);

	trc_ram #(
		.WIDTH(24),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_issue),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	result_t result_d;
	result_t result_q;

	always_comb begin
		result_d = '0;
		case (item_q.command)
			CMD_DRAW: begin
				result_d.degenerate     = (area_q == 0);
				result_d.pixels_written = count_q;
			end
			CMD_READ: begin
				if (rd_in_range) begin
					result_d.red   = ram_rdata[23:16];
					result_d.green = ram_rdata[15:8];
					result_d.blue  = ram_rdata[7:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			result_q <= result_d;
		end
	end

	assign result = result_q;

	assign status.sweep_last = sweep_last;
	assign status.area_zero  = (area_q == 0);
	assign status.box_empty  = (bx0_q > bx1_q) || (by0_q > by1_q);
	assign status.walk_last  = row_end && (y_q == by1_q);
endmodule
`default_nettype wire

FILE: src/triangle_edge_rasterizer_colormap_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_edge_rasterizer_colormap_core
// flat-shaded triangle rasterizer with jet colour ramp and frame store
// ----------------------------------------------------------------------------
// After reset the store is swept to white, one entry a cycle, before the first
// item is taken; configuration writes are taken meanwhile. A clear sweeps the
// whole store the same way. A draw computes eight setup products through one
// shared multiplier and then walks every pixel of the clamped bounding box; a
// degenerate or empty-box draw ends after setup. One item is worked on at a
// time, the single store write port setting the walk and sweep rate; the next
// item is taken while a result still waits to be transferred.
module triangle_edge_rasterizer_colormap_core import trc_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       write_enable,
	input  wire logic [1:0] register_index,
	input  wire logic [6:0] write_data,
	input  wire logic       item_valid,
	output logic            item_ready,
	input  wire item_t      item,
	output logic            result_valid,
	input  wire logic       result_ready,
	output result_t         result
);
	ctrl_cmd_t  cmd;
	dp_status_t status;

	trc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item_command (item.command),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	trc_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.write_enable   (write_enable),
		.register_index (register_index),
		.write_data     (write_data),
		.item           (item),
		.cmd            (cmd),
		.status         (status),
		.result         (result)
	);
endmodule
`default_nettype wire

FILE: sim/tb_triangle_edge_rasterizer_colormap_core.sv
// ----------------------------------------------------------------------------
// tb_triangle_edge_rasterizer_colormap_core
// drives clear, draw and read commands through the rasterizer and checks every
// result against an in-bench model of the frame store, jet ramp and edge test
// ----------------------------------------------------------------------------
module tb_triangle_edge_rasterizer_colormap_core;
	import trc_pkg::*;

	localparam int IMG_W = 64;
	localparam int IMG_H = 64;
	localparam int STALL_LIMIT = 40000;

	logic        clk;
	logic        arst_n;
	logic        write_enable;
	logic [1:0]  register_index;
	logic [6:0]  write_data;
	logic        item_valid;
	logic        item_ready;
	item_t       item;
	logic        result_valid;
	logic        result_ready;
	result_t     result;

	triangle_edge_rasterizer_colormap_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.write_enable   (write_enable),
		.register_index (register_index),
		.write_data     (write_data),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.item           (item),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.result         (result)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// in-bench copy of the block state
	logic [23:0] pixel_mem [IMG_W*IMG_H];
	logic [6:0]  width_reg;
	logic [6:0]  height_reg;
	result_t     pending_q [$];

	int errors;
	int sent;
	int got;
	int draws;
	int degen_seen;
	int reads;
	int idle_pct_send;
	int idle_pct_recv;
	int hold_off;
	int quiet_cycles;
	bit finished;

	function automatic logic [23:0] ramp_rgb(input logic [15:0] lv);
		int d;
		int lo;
		int hi;
		d  = lv[13:0];
		lo = (255 * d) >>> 14;
		hi = (255 * d + 16383) >>> 14;
		case (lv[15:14])
			2'd0:    return {8'd0, 8'(lo), 8'd255};
			2'd1:    return {8'd0, 8'd255, 8'(255 - hi)};
			2'd2:    return {8'(lo), 8'd255, 8'd0};
			default: return {8'd255, 8'(255 - hi), 8'd0};
		endcase
	endfunction

	function automatic longint edge_fn(input longint ax, input longint ay,
		input longint bx, input longint by, input longint px, input longint py);
		return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
	endfunction

	function automatic longint fl16(input longint v);
		return (v >= 0) ? v / 16 : -((-v + 15) / 16);
	endfunction

	function automatic longint cl16(input longint v);
		return (v >= 0) ? (v + 15) / 16 : -((-v) / 16);
	endfunction

	function automatic longint clamp_size(input logic [6:0] v, input longint m);
		longint s;
		s = v;
		if (s < 1) s = 1;
		if (s > m) s = m;
		return s;
	endfunction

	// applies one command to the model and returns the result it gives
	function automatic result_t rasterize(input item_t it);
		result_t r;
		longint x0, y0, x1, y1, x2, y2, area, bx0, bx1, by0, by1, w, h;
		longint e0, e1, e2, px, py;
		logic [23:0] rgb;
		int cnt;
		bit hit;
		r = '0;
		cnt = 0;
		case (it.command)
			CMD_CLEAR: begin
				foreach (pixel_mem[i]) pixel_mem[i] = WHITE;
			end
			CMD_DRAW: begin
				x0 = it.vertex_a_x; y0 = it.vertex_a_y;
				x1 = it.vertex_b_x; y1 = it.vertex_b_y;
				x2 = it.vertex_c_x; y2 = it.vertex_c_y;
				rgb = ramp_rgb(it.color_level);
				w = clamp_size(width_reg, IMG_W);
				h = clamp_size(height_reg, IMG_H);
				area = edge_fn(x0, y0, x1, y1, x2, y2);
				if (area == 0) begin
					r.degenerate = 1'b1;
					return r;
				end
				bx0 = fl16((x0 < x1) ? ((x0 < x2) ? x0 : x2) : ((x1 < x2) ? x1 : x2));
				by0 = fl16((y0 < y1) ? ((y0 < y2) ? y0 : y2) : ((y1 < y2) ? y1 : y2));
				bx1 = cl16((x0 > x1) ? ((x0 > x2) ? x0 : x2) : ((x1 > x2) ? x1 : x2));
				by1 = cl16((y0 > y1) ? ((y0 > y2) ? y0 : y2) : ((y1 > y2) ? y1 : y2));
				if (bx0 < 0) bx0 = 0;
				if (by0 < 0) by0 = 0;
				if (bx1 > w - 1) bx1 = w - 1;
				if (by1 > h - 1) by1 = h - 1;
				for (longint y = by0; y <= by1; y++) begin
					for (longint x = bx0; x <= bx1; x++) begin
						px = 16 * x + 8;
						py = 16 * y + 8;
						e0 = edge_fn(x1, y1, x2, y2, px, py);
						e1 = edge_fn(x2, y2, x0, y0, px, py);
						e2 = edge_fn(x0, y0, x1, y1, px, py);
						hit = (area > 0) ? (e0 >= 0 && e1 >= 0 && e2 >= 0)
							: (e0 <= 0 && e1 <= 0 && e2 <= 0);
						if (hit) begin
							pixel_mem[y * IMG_W + x] = rgb;
							if (cnt < COUNT_MAX) cnt++;
						end
					end
				end
				r.pixels_written = 13'(cnt);
			end
			CMD_READ: begin
				rgb = pixel_mem[int'(it.read_row) * IMG_W + int'(it.read_column)];
				r.red   = rgb[23:16];
				r.green = rgb[15:8];
				r.blue  = rgb[7:0];
			end
			default: ;
		endcase
		return r;
	endfunction

	// directed table
	typedef struct {
		item_t   it;
		bit      typed;
		result_t want;
	} directed_row_t;

	directed_row_t directed_rows [$];

	function automatic item_t mk(input logic [1:0] c, input int ax, input int ay,
		input int bx, input int by, input int cx, input int cy, input int lv,
		input int col, input int row);
		item_t it;
		it.command = c;
		it.vertex_a_x = 16'(ax); it.vertex_a_y = 16'(ay);
		it.vertex_b_x = 16'(bx); it.vertex_b_y = 16'(by);
		it.vertex_c_x = 16'(cx); it.vertex_c_y = 16'(cy);
		it.color_level = 16'(lv);
		it.read_column = 6'(col);
		it.read_row = 6'(row);
		return it;
	endfunction

	function automatic result_t rgb_res(input logic [23:0] p);
		result_t r;
		r = '0;
		r.red = p[23:16]; r.green = p[15:8]; r.blue = p[7:0];
		return r;
	endfunction

	function automatic result_t degen_res();
		result_t r;
		r = '0;
		r.degenerate = 1'b1;
		return r;
	endfunction

	task automatic add_row(input item_t it, input bit typed, input result_t want);
		directed_row_t d;
		d.it = it; d.typed = typed; d.want = want;
		directed_rows.push_back(d);
	endtask

	task automatic build_directed();
		// after reset: white, corners
		add_row(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, rgb_res(WHITE));
		add_row(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 63, 63), 1, rgb_res(WHITE));
		// degenerate: all same point, collinear
		add_row(mk(CMD_DRAW, 100, 100, 100, 100, 100, 100, 0, 0, 0), 1, degen_res());
		add_row(mk(CMD_DRAW, 0, 0, 160, 160, 320, 320, 1234, 0, 0), 1, degen_res());
		// full-screen triangles of both windings at the ramp extremes, then smaller ones at segment edges
		add_row(mk(CMD_DRAW, -16000, -16000, 32767, -16000, -16000, 32767, 0, 0, 0),
			0, '0);
		add_row(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 5, 5), 1, rgb_res(24'h0000FF));
		add_row(mk(CMD_DRAW, -16000, -16000, -16000, 32767, 32767, -16000, 65535, 0, 0),
			0, '0);
		add_row(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, rgb_res(24'hFF0000));
		add_row(mk(CMD_DRAW, 0, 0, 320, 0, 0, 320, 16384, 0, 0), 0, '0);
		add_row(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 1, 1), 1, rgb_res(24'h00FFFF));
		add_row(mk(CMD_DRAW, 0, 0, 0, 320, 320, 0, 32768, 0, 0), 0, '0);
		add_row(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 2, 2), 1, rgb_res(24'h00FF00));
		add_row(mk(CMD_DRAW, 16, 16, 200, 40, 60, 300, 49152, 0, 0), 0, '0);
		add_row(mk(CMD_DRAW, 16, 16, 200, 40, 60, 300, 16383, 0, 0), 0, '0);
		add_row(mk(CMD_DRAW, 500, 500, 900, 520, 600, 1000, 49151, 0, 0), 0, '0);
		add_row(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 40, 40), 0, '0);
		// entirely off-screen: empty box
		add_row(mk(CMD_DRAW, -800, -800, -400, -800, -800, -400, 100, 0, 0),
			0, '0);
		add_row(mk(CMD_DRAW, 2000, 2000, 3000, 2000, 2000, 3000, 100, 0, 0), 0, '0);
		// unused command
		add_row(mk(2'd3, 1, 2, 3, 4, 5, 6, 7, 8, 9), 1, '0);
		// clear then read back white
		add_row(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '0);
		add_row(mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 3, 4), 1, rgb_res(WHITE));
	endtask

	// sender, entered at a falling edge; valid is dropped by the next idle
	// cycle or by drain
	task automatic send_item(input item_t it);
		while (idle_pct_send != 0 && $urandom_range(99) < idle_pct_send) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		pending_q.push_back(rasterize(it));
		sent++;
		if (it.command == CMD_DRAW) draws++;
		if (it.command == CMD_READ) reads++;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (pending_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
		@(negedge clk);
		write_enable <= 1'b1;
		register_index <= idx;
		write_data <= val;
		if (idx == REG_WIDTH) width_reg = val;
		else if (idx == REG_HEIGHT) height_reg = val;
		@(negedge clk);
		write_enable <= 1'b0;
	endtask

	function automatic int rnd_coord();
		case ($urandom_range(9))
			0:       return $urandom_range(65535) - 32768;
			1:       return $urandom_range(2000) - 1000;
			default: return $urandom_range(1100) - 40;
		endcase
	endfunction

	function automatic item_t rnd_item();
		item_t it;
		int k;
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		it = item_t'(raw[$bits(item_t)-1:0]);
		k = $urandom_range(99);
		if (k < 3) it.command = CMD_CLEAR;
		else if (k < 5) it.command = 2'd3;
		else if (k < 55) it.command = CMD_DRAW;
		else it.command = CMD_READ;
		if (it.command == CMD_DRAW && $urandom_range(4) != 0) begin
			// mostly triangles with vertices near the image
			it.vertex_a_x = 16'(rnd_coord()); it.vertex_a_y = 16'(rnd_coord());
			it.vertex_b_x = 16'(rnd_coord()); it.vertex_b_y = 16'(rnd_coord());
			it.vertex_c_x = 16'(rnd_coord()); it.vertex_c_y = 16'(rnd_coord());
			if ($urandom_range(9) == 0) begin
				it.vertex_c_x = it.vertex_a_x;
				it.vertex_c_y = it.vertex_a_y;
			end
		end
		return it;
	endfunction

	task automatic run_random(input int n, input int s_pct, input int r_pct);
		idle_pct_send = s_pct;
		idle_pct_recv = r_pct;
		repeat (n) send_item(rnd_item());
	endtask

	// receiver and checker
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && result_valid && result_ready) begin
			got++;
			if (pending_q.size() == 0) begin
				$error("unexpected result transfer");
				errors++;
			end else begin
				exp_r = pending_q.pop_front();
				if (result.red !== exp_r.red) begin
					$error("red exp %0d got %0d", exp_r.red, result.red); errors++;
				end
				if (result.green !== exp_r.green) begin
					$error("green exp %0d got %0d", exp_r.green, result.green); errors++;
				end
				if (result.blue !== exp_r.blue) begin
					$error("blue exp %0d got %0d", exp_r.blue, result.blue); errors++;
				end
				if (result.degenerate !== exp_r.degenerate) begin
					$error("degenerate exp %0d got %0d", exp_r.degenerate,
						result.degenerate); errors++;
				end
				if (exp_r.degenerate) degen_seen++;
				if (result.pixels_written !== exp_r.pixels_written) begin
					$error("pixels_written exp %0d got %0d", exp_r.pixels_written,
						result.pixels_written); errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= !(idle_pct_recv != 0 && $urandom_range(99) < idle_pct_recv);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT && !finished) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		item_t it;
		errors = 0; sent = 0; got = 0; draws = 0; degen_seen = 0; reads = 0;
		idle_pct_send = 0; idle_pct_recv = 0; hold_off = 0; quiet_cycles = 0;
		finished = 0;
		arst_n = 1'b0;
		write_enable = 1'b0; register_index = '0; write_data = '0;
		item_valid = 1'b0; item = '0; result_ready = 1'b0;
		foreach (pixel_mem[i]) pixel_mem[i] = WHITE;
		width_reg = 7'd64; height_reg = 7'd64;
		build_directed();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].it);
			if (directed_rows[i].typed) pending_q[$] = directed_rows[i].want;
		end
		drain();

		// no idling, default size
		run_random(30, 0, 0);
		drain();

		// small image
		write_reg(REG_WIDTH, 7'd1);
		write_reg(REG_HEIGHT, 7'd1);
		run_random(15, 74, 0);
		drain();

		// zero and oversized sizes, unknown index ignored
		write_reg(REG_WIDTH, 7'd0);
		write_reg(REG_HEIGHT, 7'd127);
		write_reg(2'd3, 7'd5);
		run_random(20, 0, 74);
		// long receiver hold-off while items keep coming
		hold_off = 300;
		run_random(8, 0, 0);
		drain();

		write_reg(REG_WIDTH, 7'd23);
		write_reg(REG_HEIGHT, 7'd64);
		run_random(20, 7, 7);
		drain();

		write_reg(REG_WIDTH, 7'd64);
		write_reg(REG_HEIGHT, 7'd9);
		run_random(20, 74, 74);
		drain();
		for (int i = 0; i < 6; i++) begin
			it = mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, $urandom_range(63), $urandom_range(63));
			send_item(it);
		end
		drain();

		finished = 1;
		$display("covered %0d items (%0d draws, %0d reads), %0d results, %0d zero-area",
			sent, draws, reads, got, degen_seen);
		$display("register sweep: widths 1, 0, 23, 64; heights 1, 127, 64, 9");
		if (errors == 0 && pending_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
